// File: rtl/core/i2cram_pkg.sv
`default_nettype none

package i2cram_pkg;

  localparam int unsigned DevAddrWidth = 7;
  localparam int unsigned ByteWidth    = 8;
  localparam logic [DevAddrWidth-1:0] DevAddrReset = 7'd45;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_RSVD  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_WDEV    = 4'd2,
    PH_ACK_A   = 4'd3,
    PH_WREG    = 4'd4,
    PH_ACK_B   = 4'd5,
    PH_WDATA   = 4'd6,
    PH_ACK_C   = 4'd7,
    PH_STOP    = 4'd8,
    PH_RESTART = 4'd9,
    PH_WDEVR   = 4'd10,
    PH_ACK_D   = 4'd11,
    PH_RBYTE   = 4'd12,
    PH_ACK_E   = 4'd13
  } phase_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [ByteWidth-1:0] reg_address;
    logic [ByteWidth-1:0] write_data;
    logic                 sda_in;
  } item_t;

  typedef struct packed {
    logic                 scl;
    logic                 sda_out;
    logic                 sda_drive;
    logic                 busy_res;
    logic                 done_res;
    logic [ByteWidth-1:0] read_data;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/i2cram_in_if.sv
`default_nettype none

interface i2cram_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] reg_address;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, action, reg_address, write_data, sda_in, input ready);
  modport sink   (input valid, action, reg_address, write_data, sda_in, output ready);
endinterface

`default_nettype wire

// File: rtl/core/i2cram_out_if.sv
`default_nettype none

interface i2cram_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;

  modport source (output valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
                  input ready);
  modport sink   (input valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/i2cram_engine.sv
`default_nettype none

// Bus sequencer: holds the transaction state and works out one tick of the
// waveform for the item in the input register.
module i2cram_engine
  import i2cram_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    adv,
  input  wire item_t                   item,
  input  wire logic                    cfg_wr_en,
  input  wire logic [DevAddrWidth-1:0] cfg_wr_data,
  output result_t                      result
);

  logic [DevAddrWidth-1:0] device_address;
  phase_t                  phase, phase_next;
  logic [1:0]              tick_count, tick_count_next;
  logic [3:0]              bit_count, bit_count_next;
  logic [ByteWidth-1:0]    shift_byte, shift_byte_next;
  logic                    is_read, is_read_next;
  logic [ByteWidth-1:0]    held_reg_address, held_reg_address_next;
  logic [ByteWidth-1:0]    held_write_data, held_write_data_next;
  logic [ByteWidth-1:0]    last_read, last_read_next;
  logic                    sda_level, sda_level_next;

  logic       scl, sda, drv, busy, done, by_bits;
  logic [3:0] pos, len;
  logic [2:0] bit_idx;
  phase_t     nxt;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DevAddrReset;
    end else if (cfg_wr_en) begin
      device_address <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_count       <= '0;
      bit_count        <= '0;
      shift_byte       <= '0;
      is_read          <= 1'b0;
      held_reg_address <= '0;
      held_write_data  <= '0;
      last_read        <= '0;
      sda_level        <= 1'b1;
    end else if (adv) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      bit_count        <= bit_count_next;
      shift_byte       <= shift_byte_next;
      is_read          <= is_read_next;
      held_reg_address <= held_reg_address_next;
      held_write_data  <= held_write_data_next;
      last_read        <= last_read_next;
      sda_level        <= sda_level_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    tick_count_next       = tick_count;
    bit_count_next        = bit_count;
    shift_byte_next       = shift_byte;
    is_read_next          = is_read;
    held_reg_address_next = held_reg_address;
    held_write_data_next  = held_write_data;
    last_read_next        = last_read;
    sda_level_next        = sda_level;
    scl     = 1'b1;
    sda     = 1'b1;
    drv     = 1'b1;
    busy    = 1'b1;
    done    = 1'b0;
    len     = 4'd2;
    nxt     = PH_IDLE;
    by_bits = 1'b0;

    // Idle, or an unknown code: a request starts the START condition at once.
    if (phase == PH_IDLE || phase > PH_ACK_E) begin
      phase_next = PH_IDLE;
      if (item.action == ACT_WRITE || item.action == ACT_READ) begin
        is_read_next          = (item.action == ACT_READ);
        held_reg_address_next = item.reg_address;
        held_write_data_next  = item.write_data;
        phase_next            = PH_START;
        tick_count_next       = '0;
        bit_count_next        = '0;
      end
    end

    pos     = {2'b00, tick_count_next};
    bit_idx = 3'(4'd8 - bit_count_next);

    unique case (phase_next)
      PH_START: begin
        by_bits = 1'b1;
        pos     = bit_count_next;
        len     = 4'd6;
        nxt     = PH_WDEV;
        sda     = (pos < 4'd2) ? sda_level : (pos < 4'd4);
        sda_level_next = sda;
      end
      PH_WDEV, PH_WREG, PH_WDATA, PH_WDEVR: begin
        by_bits = 1'b1;
        pos     = bit_count_next;
        len     = 4'd10;
        if (phase_next == PH_WDEV) begin
          nxt = PH_ACK_A;
        end else if (phase_next == PH_WREG) begin
          nxt = is_read_next ? PH_RESTART : PH_ACK_B;
        end else if (phase_next == PH_WDATA) begin
          nxt = PH_ACK_C;
        end else begin
          nxt = PH_ACK_D;
        end
        if (pos == 4'd0 || pos >= 4'd9) begin
          scl = 1'b0;
          sda = sda_level;
        end else begin
          sda = shift_byte_next[bit_idx];
          sda_level_next = sda;
        end
      end
      PH_ACK_A, PH_ACK_B, PH_ACK_C, PH_ACK_D, PH_ACK_E: begin
        drv = 1'b0;
        sda = 1'b0;
        if (phase_next == PH_ACK_A) begin
          nxt = PH_WREG;
        end else if (phase_next == PH_ACK_B) begin
          nxt = PH_WDATA;
        end else if (phase_next == PH_ACK_D) begin
          nxt = PH_RBYTE;
        end else begin
          nxt = PH_STOP;
        end
      end
      PH_RESTART: begin
        len = 4'd4;
        nxt = PH_WDEVR;
        scl = (pos == 4'd0 || pos == 4'd3);
        sda = (pos < 4'd2) ? sda_level : 1'b1;
        sda_level_next = (pos == 4'd3) ? 1'b0 : sda;
      end
      PH_RBYTE: begin
        by_bits = 1'b1;
        pos     = bit_count_next;
        len     = 4'd9;
        nxt     = PH_ACK_E;
        drv     = 1'b0;
        sda     = 1'b0;
        scl     = (pos != 4'd0);
        if (pos < 4'd8) begin
          shift_byte_next = {shift_byte_next[ByteWidth-2:0], item.sda_in};
        end
      end
      PH_STOP: begin
        sda = 1'b0;
        sda_level_next = 1'b0;
        scl = pos[0];
        if (pos >= 4'd1) begin
          done = 1'b1;
          if (is_read_next) begin
            last_read_next = shift_byte_next;
          end
          sda_level_next = 1'b1;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase

    if (busy) begin
      if (({1'b0, pos} + 5'd1) >= {1'b0, len}) begin
        phase_next      = nxt;
        tick_count_next = '0;
        bit_count_next  = '0;
        case (nxt)
          PH_WDEV:  shift_byte_next = {device_address, 1'b0};
          PH_WREG:  shift_byte_next = held_reg_address_next;
          PH_WDATA: shift_byte_next = held_write_data_next;
          PH_WDEVR: shift_byte_next = {device_address, 1'b1};
          PH_RBYTE: shift_byte_next = '0;
          default: ;
        endcase
      end else if (by_bits) begin
        bit_count_next = bit_count_next + 4'd1;
      end else begin
        tick_count_next = tick_count_next + 2'd1;
      end
    end

    result.scl       = scl;
    result.sda_out   = sda;
    result.sda_drive = drv;
    result.busy_res  = busy;
    result.done_res  = done;
    result.read_data = last_read_next;
  end

endmodule

`default_nettype wire

// File: rtl/core/i2c_register_access_master.sv
`default_nettype none

// Register-access I2C master driven by a tick stream. Every beat on req is one
// bus time tick (the 1 us delay unit of the original firmware) and produces
// exactly one beat on rsp that carries the SCL level, the SDA level and its
// drive enable for that tick, plus busy, done and the last byte read. A write
// or read request is taken from a beat only while the master is idle; the beat
// that takes it is already the first tick of START. The block takes one beat
// per clock cycle while rsp is not stalled. The input register holds a beat,
// the one-tick sequencer step is computed from it, and the result register takes
// its result for rsp; a stall on rsp keeps the beat in the input register.
// The result register lets a new beat enter while an earlier result
// still waits on rsp. The user must write the device address (reset value 45)
// through cfg_wr_en/cfg_wr_data only while the master is idle; the block does
// not enforce this. Acknowledge bits are clocked but not checked.
module i2c_register_access_master
  import i2cram_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wr_en,
  input  wire logic [DevAddrWidth-1:0] cfg_wr_data,
  i2cram_in_if.sink                    req,
  i2cram_out_if.source                 rsp
);

  // Input register stage.
  logic    in_valid;
  item_t   in_item;
  // Result register stage.
  logic    out_valid;
  result_t out_data;
  result_t step_result;
  logic    adv;

  // The held beat moves on whenever the result register is free or drains.
  assign adv       = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.action      <= req.action;
      in_item.reg_address <= req.reg_address;
      in_item.write_data  <= req.write_data;
      in_item.sda_in      <= req.sda_in;
    end
  end

  i2cram_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .item        (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= step_result;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.scl       = out_data.scl;
  assign rsp.sda_out   = out_data.sda_out;
  assign rsp.sda_drive = out_data.sda_drive;
  assign rsp.busy_res  = out_data.busy_res;
  assign rsp.done_res  = out_data.done_res;
  assign rsp.read_data = out_data.read_data;

endmodule

`default_nettype wire

// File: rtl/core/i2cram_checker.sv
`default_nettype none

module i2cram_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic       scl,
  input wire logic       sda_out,
  input wire logic       sda_drive,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [7:0] read_data
);

  // The STOP tick is still part of the transaction.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && done_res |-> busy_res)
    else $error("done without busy");

  // An idle bus is released high with SDA driven high.
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !busy_res |-> scl && sda_out && sda_drive && !done_res)
    else $error("idle tick with bus not at rest");

  // A released SDA always reports a low output level.
  a_release_low: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !sda_drive |-> !sda_out)
    else $error("released SDA with high output level");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(scl)
      && $stable(sda_out) && $stable(sda_drive) && $stable(busy_res)
      && $stable(done_res))
    else $error("stalled result beat changed");

endmodule

bind i2c_register_access_master i2cram_checker u_i2cram_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .scl       (rsp.scl),
  .sda_out   (rsp.sda_out),
  .sda_drive (rsp.sda_drive),
  .busy_res  (rsp.busy_res),
  .done_res  (rsp.done_res),
  .read_data (rsp.read_data)
);

`default_nettype wire
